// ===== hw/rtl/sfgm_pkg.sv =====
// Shared constants, item and record types and the owner-rank encoder
// for the sorted face group matcher. No dependencies.
package sfgm_pkg;

  localparam int MAX_RANKS   = 64;
  localparam int ID_BITS     = 40;
  localparam int ID_W        = ID_BITS + 1;
  localparam int PATCH_W     = 17;
  localparam int NUM_ENTRIES = MAX_RANKS + 1;
  localparam int IDX_W       = 7;
  localparam int CFG_W       = 7;
  localparam int FACE_W      = 3;
  localparam int FACE_HI_W   = 8;
  localparam int OWN_W       = 6;
  localparam int OWN_HI_W    = 7;

  localparam logic [FACE_HI_W-1:0] NO_FACE = 8'd255;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_FACE  = 2'd1,
    OP_FLUSH = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_INTERIOR = 2'd0,
    ST_BOUNDARY = 2'd1,
    ST_ERROR    = 2'd2
  } status_t;

  typedef struct packed {
    logic [1:0]         op;
    logic [ID_W-1:0]    key0;
    logic [ID_W-1:0]    key1;
    logic [ID_W-1:0]    key2;
    logic [ID_W-1:0]    key3;
    logic [ID_W-1:0]    cell_id;
    logic [PATCH_W-1:0] patch_id;
    logic [FACE_W-1:0]  local_face;
    logic               is_surface;
    logic [IDX_W-1:0]   table_index;
    logic [ID_BITS-1:0] table_value;
  } in_item_t;

  // Closed-group record before the owner ranks are attached
  typedef struct packed {
    status_t              status;
    logic [ID_W-1:0]      key0;
    logic [ID_W-1:0]      key1;
    logic [ID_W-1:0]      key2;
    logic [ID_W-1:0]      key3;
    logic [ID_W-1:0]      cell_low;
    logic [ID_W-1:0]      cell_high;
    logic [PATCH_W-1:0]   face_patch;
    logic [FACE_W-1:0]    face_low;
    logic [FACE_HI_W-1:0] face_high;
  } face_rec_t;

  // First entry above the id, minus one, clamped to 0..rc-1.
  // hits are already masked to entries 0..rc.
  function automatic logic [OWN_W-1:0] owner_of(input logic [NUM_ENTRIES-1:0] hits,
                                                 input logic [IDX_W-1:0] rc);
    logic [IDX_W-1:0] pos;
    logic [IDX_W-1:0] own;
    pos = rc + IDX_W'(1);
    for (int i = NUM_ENTRIES - 1; i >= 0; i--) begin
      if (hits[i]) begin
        pos = IDX_W'(i);
      end
    end
    if (pos == '0) begin
      own = '0;
    end else if (pos > rc) begin
      own = rc - IDX_W'(1);
    end else begin
      own = pos - IDX_W'(1);
    end
    return own[OWN_W-1:0];
  endfunction

endpackage

// ===== hw/rtl/sorted_face_group_matcher.sv =====
// Sorted face group matcher top level: input register, group tracker,
// rank compare stage, owner encode and output register. Uses sfgm_pkg,
// sfgm_group and sfgm_rank_table.
//
//  channel  dir  ports                          item
//  in       in   in_tvalid/tready/tdata/tuser   half-face, table load or flush
//  out      out  out_tvalid/tready/tdata/tuser  closed face record
//  cfg      in   cfg_wr_en/cfg_wr_data          rank_count, write only
//
// One item is taken per cycle while the output is not stalled; the record of the
// group an item closes passes the input reg, record reg, compare reg and output reg.
// Each stage moves when the one after it is empty or moving, so the block
// keeps accepting while a result waits at the output, until the stages fill.
// Reset (synchronous, rst_n low) empties the pipe, closes the group and sets
// rank_count to 1. The boundary table is not cleared; load it before use.
module sorted_face_group_matcher (
  input  logic         clk,
  input  logic         rst_n,
  // in_tdata, from bit 0: key_node0, key_node1, key_node2, key_node3,
  // cell_id, patch_id, local_face, table_index, table_value
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [271:0] in_tdata,
  // in_tuser, from bit 0: op[1:0], is_surface
  input  logic [2:0]   in_tuser,
  // out_tdata, from bit 0: out_key0, out_key1, out_key2, out_key3, cell_low,
  // cell_high, face_patch, face_low, face_high, owner_low, owner_high, pad
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [287:0] out_tdata,
  // out_tuser: status
  output logic [1:0]   out_tuser,
  input  logic         cfg_wr_en,
  input  logic [6:0]   cfg_wr_data
);

  localparam int IDW = sfgm_pkg::ID_W;

  // ---------------------------------------------------------------- config
  logic [sfgm_pkg::CFG_W-1:0] rank_count_r;
  logic [sfgm_pkg::IDX_W-1:0] rc_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rank_count_r <= sfgm_pkg::CFG_W'(1);
    end else if (cfg_wr_en) begin
      rank_count_r <= cfg_wr_data;
    end
  end

  // zero counts as one rank, large values saturate at MAX_RANKS (64)
  always_comb begin
    if (rank_count_r == '0) begin
      rc_eff = sfgm_pkg::IDX_W'(1);
    end else if (rank_count_r > sfgm_pkg::CFG_W'(sfgm_pkg::MAX_RANKS)) begin
      rc_eff = sfgm_pkg::IDX_W'(sfgm_pkg::MAX_RANKS);
    end else begin
      rc_eff = rank_count_r;
    end
  end

  // ---------------------------------------------------------- stage enables
  logic s1_v_r, s2_v_r, s3_v_r, out_v_r;
  logic s1_en, s2_en, s3_en, out_en;

  assign out_en    = !out_v_r || out_tready;
  assign s3_en     = !s3_v_r || out_en;
  assign s2_en     = !s2_v_r || s3_en;
  assign s1_en     = !s1_v_r || s2_en;
  assign in_tready = s1_en;

  // ------------------------------------------------------- stage 1: input
  sfgm_pkg::in_item_t in_item;
  sfgm_pkg::in_item_t s1_item_r;

  always_comb begin
    in_item.op          = in_tuser[1:0];
    in_item.is_surface  = in_tuser[2];
    in_item.key0        = in_tdata[40:0];
    in_item.key1        = in_tdata[81:41];
    in_item.key2        = in_tdata[122:82];
    in_item.key3        = in_tdata[163:123];
    in_item.cell_id     = in_tdata[204:164];
    in_item.patch_id    = in_tdata[221:205];
    in_item.local_face  = in_tdata[224:222];
    in_item.table_index = in_tdata[231:225];
    in_item.table_value = in_tdata[271:232];
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && s1_en) begin
      s1_item_r <= in_item;
    end
  end

  // --------------------------------------------- group tracking on stage 1
  logic                s1_adv;
  logic                grp_rec_valid;
  sfgm_pkg::face_rec_t grp_rec;
  logic                s1_load_ok;

  assign s1_adv = s1_v_r && s2_en;

  sfgm_group u_group (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (s1_v_r),
    .advance    (s1_adv),
    .item       (s1_item_r),
    .rec_valid  (grp_rec_valid),
    .rec        (grp_rec)
  );

  // loads past the table end are dropped here
  assign s1_load_ok = (s1_item_r.op == sfgm_pkg::OP_LOAD) &&
                      (s1_item_r.table_index <= sfgm_pkg::IDX_W'(sfgm_pkg::MAX_RANKS));

  // ----------------------------------- stage 2: record or table load item
  logic                         s2_load_r;
  sfgm_pkg::face_rec_t          s2_rec_r;
  logic [sfgm_pkg::IDX_W-1:0]   s2_idx_r;
  logic [sfgm_pkg::ID_BITS-1:0] s2_val_r;

  always_ff @(posedge clk) begin
    if (s2_en) begin
      s2_load_r <= s1_load_ok;
      s2_rec_r  <= grp_rec;
      s2_idx_r  <= s1_item_r.table_index;
      s2_val_r  <= s1_item_r.table_value;
    end
  end

  // Loads write the table as they leave stage 2, so records ahead of them
  // have already compared and records behind them see the new entry.
  logic                               tbl_wr;
  logic [sfgm_pkg::NUM_ENTRIES-1:0]   hit_low, hit_high;

  assign tbl_wr = s2_v_r && s2_load_r && s3_en;

  sfgm_rank_table u_table (
    .clk       (clk),
    .wr_en     (tbl_wr),
    .wr_idx    (s2_idx_r),
    .wr_val    (s2_val_r),
    .rc        (rc_eff),
    .cell_low  (s2_rec_r.cell_low),
    .cell_high (s2_rec_r.cell_high),
    .hit_low   (hit_low),
    .hit_high  (hit_high)
  );

  // ------------------------------------------- stage 3: registered compares
  sfgm_pkg::face_rec_t              s3_rec_r;
  logic [sfgm_pkg::NUM_ENTRIES-1:0] s3_hit_low_r, s3_hit_high_r;

  always_ff @(posedge clk) begin
    if (s3_en) begin
      s3_rec_r      <= s2_rec_r;
      s3_hit_low_r  <= hit_low;
      s3_hit_high_r <= hit_high;
    end
  end

  // --------------------------------------- owner encode and output register
  logic [sfgm_pkg::OWN_W-1:0]    own_low, own_high;
  logic [sfgm_pkg::OWN_W-1:0]    owner_low_nxt;
  logic [sfgm_pkg::OWN_HI_W-1:0] owner_high_nxt;
  sfgm_pkg::face_rec_t           out_rec_r;
  logic [sfgm_pkg::OWN_W-1:0]    owner_low_r;
  logic [sfgm_pkg::OWN_HI_W-1:0] owner_high_r;

  assign own_low  = sfgm_pkg::owner_of(s3_hit_low_r, rc_eff);
  assign own_high = sfgm_pkg::owner_of(s3_hit_high_r, rc_eff);

  always_comb begin
    unique case (s3_rec_r.status)
      sfgm_pkg::ST_INTERIOR: begin
        owner_low_nxt  = own_low;
        owner_high_nxt = {1'b0, own_high};
      end
      sfgm_pkg::ST_BOUNDARY: begin
        owner_low_nxt  = own_low;
        owner_high_nxt = '1;
      end
      default: begin
        owner_low_nxt  = '0;
        owner_high_nxt = '1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (out_en) begin
      out_rec_r    <= s3_rec_r;
      owner_low_r  <= owner_low_nxt;
      owner_high_r <= owner_high_nxt;
    end
  end

  // ----------------------------------------------------------- valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (s1_en) begin
        s1_v_r <= in_tvalid;
      end
      if (s2_en) begin
        s2_v_r <= s1_v_r && (grp_rec_valid || s1_load_ok);
      end
      if (s3_en) begin
        s3_v_r <= s2_v_r && !s2_load_r;
      end
      if (out_en) begin
        out_v_r <= s3_v_r;
      end
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tuser  = out_rec_r.status;
  assign out_tdata  = {1'b0, owner_high_r, owner_low_r, out_rec_r.face_high,
                       out_rec_r.face_low, out_rec_r.face_patch, out_rec_r.cell_high,
                       out_rec_r.cell_low, out_rec_r.key3, out_rec_r.key2,
                       out_rec_r.key1, out_rec_r.key0};

  // ----------------------------------------------------------- assertions
  a_interior_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_rec_r.status == sfgm_pkg::ST_INTERIOR |->
      $signed(out_rec_r.cell_low) <= $signed(out_rec_r.cell_high))
    else $error("interior face cells out of order");

  a_boundary_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_rec_r.status == sfgm_pkg::ST_BOUNDARY |->
      owner_high_r == '1 && out_rec_r.face_high == sfgm_pkg::NO_FACE &&
      out_rec_r.cell_high == {IDW{1'b1}})
    else $error("boundary face carries a second cell");

  a_owner_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> {1'b0, owner_low_r} < rc_eff)
    else $error("owner rank beyond rank count");

  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && !s2_en |=> s1_v_r && $stable(s1_item_r))
    else $error("stalled input item lost");

endmodule

// ===== hw/rtl/sfgm_group.sv =====
// Group tracker: holds the open key run, its volume faces and patch,
// and builds the record when a run closes. Uses sfgm_pkg.
module sfgm_group (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 item_valid,
  input  logic                 advance,
  input  sfgm_pkg::in_item_t   item,
  output logic                 rec_valid,
  output sfgm_pkg::face_rec_t  rec
);

  logic                                open_r, open_nxt;
  logic [1:0]                          vcnt_r, vcnt_nxt;
  logic                                ovf_r, ovf_nxt;
  logic [sfgm_pkg::ID_W-1:0]           key_r [4];
  logic [sfgm_pkg::ID_W-1:0]           key_nxt [4];
  logic [sfgm_pkg::ID_W-1:0]           cell_r [2];
  logic [sfgm_pkg::ID_W-1:0]           cell_nxt [2];
  logic [sfgm_pkg::FACE_W-1:0]         face_r [2];
  logic [sfgm_pkg::FACE_W-1:0]         face_nxt [2];
  logic [sfgm_pkg::PATCH_W-1:0]        patch_r, patch_nxt;

  sfgm_pkg::face_rec_t close_rec;
  logic                close_ok;
  logic                key_match;
  logic                do_close;
  logic                do_start;
  logic                do_add;
  logic [1:0]          base_vcnt;
  logic                base_ovf;
  logic                swap;

  // Record built from the current group contents
  always_comb begin
    swap                 = $signed(cell_r[0]) > $signed(cell_r[1]);
    close_rec.key0       = key_r[0];
    close_rec.key1       = key_r[1];
    close_rec.key2       = key_r[2];
    close_rec.key3       = key_r[3];
    close_rec.status     = sfgm_pkg::ST_ERROR;
    close_rec.cell_low   = '1;
    close_rec.cell_high  = '1;
    close_rec.face_patch = '1;
    close_rec.face_low   = '0;
    close_rec.face_high  = sfgm_pkg::NO_FACE;
    close_ok             = 1'b1;
    if (ovf_r) begin
      close_ok = 1'b1;
    end else if (vcnt_r == 2'd2) begin
      close_rec.status    = sfgm_pkg::ST_INTERIOR;
      close_rec.cell_low  = swap ? cell_r[1] : cell_r[0];
      close_rec.cell_high = swap ? cell_r[0] : cell_r[1];
      close_rec.face_low  = swap ? face_r[1] : face_r[0];
      close_rec.face_high = sfgm_pkg::FACE_HI_W'(swap ? face_r[0] : face_r[1]);
    end else if (vcnt_r == 2'd1) begin
      close_rec.status     = sfgm_pkg::ST_BOUNDARY;
      close_rec.cell_low   = cell_r[0];
      close_rec.face_patch = patch_r;
      close_rec.face_low   = face_r[0];
    end else begin
      close_ok = 1'b0;
    end
  end

  always_comb begin
    key_match = (item.key0 == key_r[0]) && (item.key1 == key_r[1]) &&
                (item.key2 == key_r[2]) && (item.key3 == key_r[3]);
    do_close  = 1'b0;
    do_start  = 1'b0;
    do_add    = 1'b0;
    unique case (item.op)
      sfgm_pkg::OP_FLUSH: begin
        do_close = open_r;
      end
      sfgm_pkg::OP_FACE: begin
        if (open_r && key_match) begin
          do_add = 1'b1;
        end else begin
          do_close = open_r;
          do_start = 1'b1;
          do_add   = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  assign rec_valid = item_valid && do_close && close_ok;
  assign rec       = close_rec;

  // Next group state: restart first if needed, then fold in the item
  always_comb begin
    open_nxt  = open_r;
    key_nxt   = key_r;
    cell_nxt  = cell_r;
    face_nxt  = face_r;
    patch_nxt = patch_r;
    base_vcnt = do_start ? 2'd0 : vcnt_r;
    base_ovf  = do_start ? 1'b0 : ovf_r;
    vcnt_nxt  = base_vcnt;
    ovf_nxt   = base_ovf;
    if (do_close) begin
      open_nxt = 1'b0;
    end
    if (do_start) begin
      open_nxt   = 1'b1;
      key_nxt[0] = item.key0;
      key_nxt[1] = item.key1;
      key_nxt[2] = item.key2;
      key_nxt[3] = item.key3;
      patch_nxt  = '1;
    end
    if (do_add) begin
      if (item.is_surface) begin
        patch_nxt = item.patch_id;
      end else if (base_vcnt != 2'd2) begin
        cell_nxt[base_vcnt[0]] = item.cell_id;
        face_nxt[base_vcnt[0]] = item.local_face;
        vcnt_nxt               = base_vcnt + 2'd1;
      end else begin
        ovf_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r <= 1'b0;
      vcnt_r <= 2'd0;
      ovf_r  <= 1'b0;
    end else if (advance) begin
      open_r <= open_nxt;
      vcnt_r <= vcnt_nxt;
      ovf_r  <= ovf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      patch_r <= '1;
    end else if (advance) begin
      patch_r <= patch_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      key_r  <= key_nxt;
      cell_r <= cell_nxt;
      face_r <= face_nxt;
    end
  end

endmodule

// ===== hw/rtl/sfgm_rank_table.sv =====
// Rank boundary table: one register per entry, each with its own pair of
// comparators against the two cell ids. Uses sfgm_pkg.
module sfgm_rank_table (
  input  logic                                clk,
  input  logic                                wr_en,
  input  logic [sfgm_pkg::IDX_W-1:0]          wr_idx,
  input  logic [sfgm_pkg::ID_BITS-1:0]        wr_val,
  input  logic [sfgm_pkg::IDX_W-1:0]          rc,
  input  logic [sfgm_pkg::ID_W-1:0]           cell_low,
  input  logic [sfgm_pkg::ID_W-1:0]           cell_high,
  output logic [sfgm_pkg::NUM_ENTRIES-1:0]    hit_low,
  output logic [sfgm_pkg::NUM_ENTRIES-1:0]    hit_high
);

  logic [sfgm_pkg::ID_BITS-1:0] bound_r [sfgm_pkg::NUM_ENTRIES];

  // No reset: entries are to be loaded by the user before any search uses them; the table does not enforce it
  always_ff @(posedge clk) begin
    if (wr_en) begin
      bound_r[wr_idx] <= wr_val;
    end
  end

  // hit = entry in use and strictly above the id
  always_comb begin
    for (int i = 0; i < sfgm_pkg::NUM_ENTRIES; i++) begin
      hit_low[i]  = (sfgm_pkg::IDX_W'(i) <= rc) &&
                    ($signed({1'b0, bound_r[i]}) > $signed(cell_low));
      hit_high[i] = (sfgm_pkg::IDX_W'(i) <= rc) &&
                    ($signed({1'b0, bound_r[i]}) > $signed(cell_high));
    end
  end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps
// Self-checking bench for sorted_face_group_matcher: drives table loads, half-face
// items and flushes, predicts each closed-group record and checks it. Uses sfgm_pkg.
module tb;

  localparam int MAX_RANKS   = sfgm_pkg::MAX_RANKS;
  localparam int ID_BITS     = sfgm_pkg::ID_BITS;
  localparam int ID_W        = sfgm_pkg::ID_W;
  localparam int PATCH_W     = sfgm_pkg::PATCH_W;
  localparam int NUM_ENTRIES = sfgm_pkg::NUM_ENTRIES;
  localparam int IDX_W       = sfgm_pkg::IDX_W;
  localparam int FACE_W      = sfgm_pkg::FACE_W;
  localparam int FACE_HI_W   = sfgm_pkg::FACE_HI_W;
  localparam int OWN_W       = sfgm_pkg::OWN_W;
  localparam int OWN_HI_W    = sfgm_pkg::OWN_HI_W;

  localparam int CYCLE_LIMIT  = 200000;
  // Pipe is four stages deep; the drain wait covers it with margin before touching rank_count.
  localparam int DRAIN_CYCLES = 12;

  localparam logic [1:0]         OP_UNUSED = 2'd3;
  localparam logic [ID_W-1:0]    NO_CELL   = '1;
  localparam logic [ID_W-1:0]    TOP_ID    = {1'b0, {ID_BITS{1'b1}}};
  localparam logic [PATCH_W-1:0] NO_PATCH  = '1;

  // Field order of in_tdata, highest field first so key0 lands in bit 0.
  typedef struct packed {
    logic [ID_BITS-1:0] table_value;
    logic [IDX_W-1:0]   table_index;
    logic [FACE_W-1:0]  local_face;
    logic [PATCH_W-1:0] patch_id;
    logic [ID_W-1:0]    cell_id;
    logic [ID_W-1:0]    key3;
    logic [ID_W-1:0]    key2;
    logic [ID_W-1:0]    key1;
    logic [ID_W-1:0]    key0;
  } half_face_t;

  // Field order of out_tdata, pad bit on top.
  typedef struct packed {
    logic                 pad;
    logic [OWN_HI_W-1:0]  owner_high;
    logic [OWN_W-1:0]     owner_low;
    logic [FACE_HI_W-1:0] face_high;
    logic [FACE_W-1:0]    face_low;
    logic [PATCH_W-1:0]   face_patch;
    logic [ID_W-1:0]      cell_high;
    logic [ID_W-1:0]      cell_low;
    logic [ID_W-1:0]      key3;
    logic [ID_W-1:0]      key2;
    logic [ID_W-1:0]      key1;
    logic [ID_W-1:0]      key0;
  } face_word_t;

  typedef logic [3:0][ID_W-1:0] face_key_t;

  typedef struct {
    sfgm_pkg::status_t status;
    face_word_t        word;
  } face_record_t;

  logic         clk         = 1'b0;
  logic         rst_n       = 1'b0;
  logic         in_tvalid   = 1'b0;
  logic         in_tready;
  logic [271:0] in_tdata    = '0;
  logic [2:0]   in_tuser    = '0;
  logic         out_tvalid;
  logic         out_tready  = 1'b0;
  logic [287:0] out_tdata;
  logic [1:0]   out_tuser;
  logic         cfg_wr_en   = 1'b0;
  logic [6:0]   cfg_wr_data = '0;

  sorted_face_group_matcher uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  int mismatches  = 0;
  int cycle_count = 0;

  // ---------------------------------------------------------------------------
  // Group tracker model: its own copy of the table, the open group and the rank
  // count. Records it predicts wait in face_records_due in output order.
  // ---------------------------------------------------------------------------
  logic [ID_BITS-1:0] bound_tab [NUM_ENTRIES];
  face_key_t          grp_key       = '0;
  bit                 grp_open      = 1'b0;
  int                 vol_cnt       = 0;
  bit                 overflow_seen = 1'b0;
  logic [ID_W-1:0]    held_cell [2];
  logic [FACE_W-1:0]  held_face [2];
  logic [PATCH_W-1:0] held_patch    = NO_PATCH;
  int                 rank_cnt      = 1;
  face_record_t       face_records_due [$];

  // Upper-bound search: first entry above the id, minus one, clamped to the
  // ranks in use. rank_count 0 acts as 1, anything above 64 as 64.
  function automatic int owner_rank(logic [ID_W-1:0] gid);
    int rc;
    int pos;
    int r;
    rc = rank_cnt;
    if (rc < 1) rc = 1;
    if (rc > MAX_RANKS) rc = MAX_RANKS;
    pos = rc + 1;
    for (int i = rc; i >= 0; i--) begin
      if ($signed({1'b0, bound_tab[i]}) > $signed(gid)) pos = i;
    end
    r = pos - 1;
    if (r < 0) r = 0;
    if (r > rc - 1) r = rc - 1;
    return r;
  endfunction

  task automatic close_group();
    face_record_t    rec;
    logic [ID_W-1:0] lo;
    logic [ID_W-1:0] hi;
    logic [FACE_W-1:0] flo;
    logic [FACE_W-1:0] fhi;
    grp_open = 1'b0;
    // surface-only group: nothing leaves
    if (!overflow_seen && vol_cnt == 0) return;
    rec.word      = '0;
    rec.word.key0 = grp_key[0];
    rec.word.key1 = grp_key[1];
    rec.word.key2 = grp_key[2];
    rec.word.key3 = grp_key[3];
    if (overflow_seen) begin
      // non-manifold: fixed filler in every field but the key
      rec.status          = sfgm_pkg::ST_ERROR;
      rec.word.cell_low   = NO_CELL;
      rec.word.cell_high  = NO_CELL;
      rec.word.face_patch = NO_PATCH;
      rec.word.face_low   = '0;
      rec.word.face_high  = sfgm_pkg::NO_FACE;
      rec.word.owner_low  = '0;
      rec.word.owner_high = '1;
    end else if (vol_cnt == 2) begin
      lo  = held_cell[0];
      hi  = held_cell[1];
      flo = held_face[0];
      fhi = held_face[1];
      // equal ids keep arrival order
      if ($signed(lo) > $signed(hi)) begin
        lo  = held_cell[1];
        hi  = held_cell[0];
        flo = held_face[1];
        fhi = held_face[0];
      end
      rec.status          = sfgm_pkg::ST_INTERIOR;
      rec.word.cell_low   = lo;
      rec.word.cell_high  = hi;
      rec.word.face_patch = NO_PATCH;
      rec.word.face_low   = flo;
      rec.word.face_high  = FACE_HI_W'(fhi);
      rec.word.owner_low  = OWN_W'(owner_rank(lo));
      rec.word.owner_high = OWN_HI_W'(owner_rank(hi));
    end else begin
      rec.status          = sfgm_pkg::ST_BOUNDARY;
      rec.word.cell_low   = held_cell[0];
      rec.word.cell_high  = NO_CELL;
      rec.word.face_patch = held_patch;
      rec.word.face_low   = held_face[0];
      rec.word.face_high  = sfgm_pkg::NO_FACE;
      rec.word.owner_low  = OWN_W'(owner_rank(held_cell[0]));
      rec.word.owner_high = '1;
    end
    face_records_due = {face_records_due, rec};
  endtask

  task automatic track_item(logic [1:0] op, bit surf, half_face_t d);
    face_key_t k;
    k = {d.key3, d.key2, d.key1, d.key0};
    if (op == sfgm_pkg::OP_LOAD) begin
      if (d.table_index <= MAX_RANKS) bound_tab[d.table_index] = d.table_value;
    end else if (op == sfgm_pkg::OP_FLUSH) begin
      if (grp_open) close_group();
    end else if (op == sfgm_pkg::OP_FACE) begin
      if (!(grp_open && k == grp_key)) begin
        if (grp_open) close_group();
        grp_key       = k;
        grp_open      = 1'b1;
        vol_cnt       = 0;
        overflow_seen = 1'b0;
        held_cell[0]  = '0;
        held_cell[1]  = '0;
        held_face[0]  = '0;
        held_face[1]  = '0;
        held_patch    = NO_PATCH;
      end
      if (surf) begin
        held_patch = d.patch_id;
      end else if (vol_cnt < 2) begin
        held_cell[vol_cnt] = d.cell_id;
        held_face[vol_cnt] = d.local_face;
        vol_cnt++;
      end else begin
        overflow_seen = 1'b1;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sender: bursts of back-to-back items, then a random gap.
  // ---------------------------------------------------------------------------
  int burst_left = 0;

  task automatic send_item(logic [1:0] op, bit surf, half_face_t d);
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    in_tuser  <= {surf, op};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    track_item(op, surf, d);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      // now and then a long run with no gaps at all
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                               : $urandom_range(0, 8);
    end
  endtask

  function automatic half_face_t noise_word();
    logic [287:0] r;
    for (int i = 0; i < 9; i++) r[i*32 +: 32] = $urandom();
    return r[271:0];
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  task automatic send_face(face_key_t k, bit surf, logic [ID_W-1:0] cell_val,
                           logic [PATCH_W-1:0] patch, logic [FACE_W-1:0] lf);
    half_face_t d;
    d            = noise_word();
    d.key0       = k[0];
    d.key1       = k[1];
    d.key2       = k[2];
    d.key3       = k[3];
    d.cell_id    = cell_val;
    d.patch_id   = patch;
    d.local_face = lf;
    send_item(sfgm_pkg::OP_FACE, surf, d);
  endtask

  task automatic send_load(int idx, logic [ID_BITS-1:0] val);
    half_face_t d;
    d             = noise_word();
    d.table_index = IDX_W'(idx);
    d.table_value = val;
    send_item(sfgm_pkg::OP_LOAD, 1'($urandom_range(0, 1)), d);
  endtask

  task automatic send_ctl(logic [1:0] op);
    send_item(op, 1'($urandom_range(0, 1)), noise_word());
  endtask

  task automatic set_rank_count(int v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= 7'(v);
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    rank_cnt = v;
  endtask

  // Close the open group, then wait out every record and the pipe itself.
  task automatic flush_and_drain();
    send_ctl(sfgm_pkg::OP_FLUSH);
    in_tvalid <= 1'b0;
    while (face_records_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  face_key_t last_key = '0;

  function automatic face_key_t mk_key(longint n0, longint n1, longint n2, longint n3);
    face_key_t k;
    k[0] = ID_W'(n0);
    k[1] = ID_W'(n1);
    k[2] = ID_W'(n2);
    k[3] = ID_W'(n3);
    return k;
  endfunction

  function automatic logic [ID_W-1:0] rand_node();
    logic [ID_W-1:0] v;
    case ($urandom_range(0, 7))
      0:       v = NO_CELL;
      1:       v = TOP_ID;
      2:       v = ID_W'($urandom_range(0, 100));
      default: v = {1'b0, ID_BITS'(rand64())};
    endcase
    return v;
  endfunction

  // Mostly ids inside the table span, with hits exactly on and just below
  // a boundary entry, plus both extremes.
  function automatic logic [ID_W-1:0] rand_cell();
    logic [63:0]     span;
    logic [ID_W-1:0] v;
    span = 64'(bound_tab[MAX_RANKS]) + 64'(bound_tab[MAX_RANKS] >> 3) + 64'd1;
    case ($urandom_range(0, 9))
      0:       v = NO_CELL;
      1:       v = TOP_ID;
      2:       v = {1'b0, bound_tab[$urandom_range(0, MAX_RANKS)]};
      3:       v = {1'b0, bound_tab[$urandom_range(0, MAX_RANKS)]} - 1'b1;
      default: v = ID_W'(rand64() % span);
    endcase
    return v;
  endfunction

  function automatic logic [PATCH_W-1:0] rand_patch();
    logic [PATCH_W-1:0] p;
    case ($urandom_range(0, 5))
      0:       p = NO_PATCH;
      1:       p = 17'd65535;
      default: p = PATCH_W'($urandom_range(0, 65535));
    endcase
    return p;
  endfunction

  // One key in ten repeats the previous one, so that group merges on.
  function automatic face_key_t next_key();
    face_key_t k;
    if ($urandom_range(0, 9) == 0) begin
      k = last_key;
    end else begin
      for (int i = 0; i < 4; i++) k[i] = rand_node();
      if ($urandom_range(0, 2) == 0) k[3] = NO_CELL;  // triangle face
    end
    last_key = k;
    return k;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Fill all 65 entries in rising order; to_max puts the top id in the last.
  task automatic test_table_load(bit to_max);
    logic [63:0] stride;
    logic [63:0] v;
    stride = ($urandom_range(0, 2) == 0) ? 64'($urandom_range(1, 1000))
                                         : (rand64() % (64'd1 << 34)) + 64'd1;
    for (int i = 0; i <= MAX_RANKS; i++) begin
      v = 64'(i) * stride;
      if (v > 64'(TOP_ID) || (to_max && i == MAX_RANKS)) v = 64'(TOP_ID);
      send_load(i, v[ID_BITS-1:0]);
    end
  endtask

  task automatic test_directed();
    face_key_t ka;
    face_key_t kb;
    face_key_t kc;
    face_key_t kd;
    face_key_t ke;
    face_key_t kf;
    face_key_t kg;
    ka = mk_key(1, 2, 3, 4);
    kb = mk_key(TOP_ID, TOP_ID, TOP_ID, TOP_ID);
    kc = mk_key(0, 7, 9, -1);
    kd = mk_key(5, 6, 7, 8);
    ke = mk_key(10, 20, 30, 40);
    kf = mk_key(11, 12, 13, -1);
    kg = mk_key(-1, -1, -1, -1);
    // interior, second cell lower so the pair is swapped
    send_face(ka, 1'b0, 41'd10, NO_PATCH, 3'd5);
    send_face(ka, 1'b0, 41'd3, 17'd1, 3'd0);
    // boundary keeps the last surface patch; new key closes the interior
    send_face(kb, 1'b1, NO_CELL, 17'd7, 3'd1);
    send_face(kb, 1'b0, TOP_ID, 17'd2, 3'd5);
    send_face(kb, 1'b1, NO_CELL, 17'd65535, 3'd2);
    // boundary with no surface, cell id -1
    send_face(kc, 1'b0, NO_CELL, 17'd3, 3'd2);
    // surface-only group gives nothing
    send_face(kd, 1'b1, 41'd4, NO_PATCH, 3'd0);
    send_face(kd, 1'b1, 41'd4, 17'd100, 3'd0);
    // four volume faces: error record on flush; unknown op inside
    send_face(ke, 1'b0, 41'd1, 17'd0, 3'd1);
    send_ctl(OP_UNUSED);
    send_face(ke, 1'b0, 41'd2, 17'd0, 3'd2);
    send_face(ke, 1'b1, 41'd2, 17'd5, 3'd0);
    send_face(ke, 1'b0, 41'd3, 17'd0, 3'd3);
    send_face(ke, 1'b0, 41'd4, 17'd0, 3'd4);
    send_ctl(sfgm_pkg::OP_FLUSH);
    // flush with nothing open
    send_ctl(sfgm_pkg::OP_FLUSH);
    // loads past the table end are dropped
    send_load(65, {ID_BITS{1'b1}});
    send_load(127, '0);
    // equal cell ids keep arrival order
    send_face(kf, 1'b0, 41'd5, 17'd0, 3'd1);
    send_face(kf, 1'b0, 41'd5, 17'd0, 3'd2);
    // cell right on a table entry, all -1 key
    send_face(kg, 1'b0, {1'b0, bound_tab[1]}, 17'd0, 3'd0);
    flush_and_drain();
  endtask

  // Random groups, some over-full or surface-only, plus loads, flushes and noise.
  task automatic test_random_groups(int n);
    int              sent;
    int              pick;
    int              nvol;
    int              nsurf;
    bit              surf;
    bit              same_cell;
    face_key_t       k;
    logic [ID_W-1:0] prev_cell;
    sent = 0;
    while (sent < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
        send_load($urandom_range(0, 70), ID_BITS'(rand64()));
        sent++;
      end else if (pick < 8) begin
        send_ctl(sfgm_pkg::OP_FLUSH);
        sent++;
      end else if (pick < 10) begin
        send_ctl(OP_UNUSED);
      end else begin
        k    = next_key();
        pick = $urandom_range(0, 9);
        if (pick < 5) begin
          nvol  = 2;
          nsurf = int'($urandom_range(0, 3) == 0);
        end else if (pick < 7) begin
          nvol  = 1;
          nsurf = $urandom_range(0, 2);
        end else if (pick == 7) begin
          nvol  = 0;
          nsurf = $urandom_range(1, 2);
        end else if (pick == 8) begin
          nvol  = $urandom_range(3, 4);
          nsurf = $urandom_range(0, 1);
        end else begin
          nvol  = $urandom_range(0, 4);
          nsurf = $urandom_range(1, 2);
        end
        same_cell = ($urandom_range(0, 7) == 0);
        prev_cell = rand_cell();
        for (int left = nvol + nsurf; left > 0; left--) begin
          // spread surface items at random spots in the group
          surf = ($urandom_range(1, left) <= nsurf);
          if (surf) nsurf--;
          send_face(k, surf, same_cell ? prev_cell : rand_cell(), rand_patch(),
                    FACE_W'($urandom_range(0, 5)));
          sent++;
        end
      end
    end
    flush_and_drain();
  endtask

  // ---------------------------------------------------------------------------
  // Record checker and receiver stall pattern
  // ---------------------------------------------------------------------------
  int stall_mode = 0;
  int mode_left  = 0;
  int rx_tick    = 0;

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : record_check
    face_record_t want;
    face_word_t   got;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (face_records_due.size() == 0) begin
        mismatches++;
        $display("%0t: record with none expected, expected nothing, got status %0h data %0h",
                 $time, out_tuser, out_tdata);
      end else begin
        want = face_records_due.pop_front();
        check_field("status", 64'(want.status), 64'(out_tuser));
        check_field("out_key0", 64'(want.word.key0), 64'(got.key0));
        check_field("out_key1", 64'(want.word.key1), 64'(got.key1));
        check_field("out_key2", 64'(want.word.key2), 64'(got.key2));
        check_field("out_key3", 64'(want.word.key3), 64'(got.key3));
        check_field("cell_low", 64'(want.word.cell_low), 64'(got.cell_low));
        check_field("cell_high", 64'(want.word.cell_high), 64'(got.cell_high));
        check_field("face_patch", 64'(want.word.face_patch), 64'(got.face_patch));
        check_field("face_low", 64'(want.word.face_low), 64'(got.face_low));
        check_field("face_high", 64'(want.word.face_high), 64'(got.face_high));
        check_field("owner_low", 64'(want.word.owner_low), 64'(got.owner_low));
        check_field("owner_high", 64'(want.word.owner_high), 64'(got.owner_high));
      end
    end
    // receiver alternates between always ready, random stalls and a 1-in-4 beat
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      mode_left  = $urandom_range(16, 96);
    end else begin
      mode_left--;
    end
    rx_tick++;
    case (stall_mode)
      0:       out_tready <= 1'b1;
      1:       out_tready <= ($urandom_range(0, 2) != 0);
      default: out_tready <= (rx_tick % 4 == 0);
    endcase
  end

  // Watchdog: a hang ends the run as a failure.
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("status: fail");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Sequence: table fill, directed cases, then random phases at several
  // rank counts, extremes and out-of-range values among them, and a table refill.
  // ---------------------------------------------------------------------------
  initial begin : main_seq
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_table_load(1'b1);
    test_directed();
    test_random_groups(50);
    set_rank_count(MAX_RANKS);
    test_random_groups(40);
    set_rank_count(0);          // acts as one rank
    test_random_groups(40);
    set_rank_count(127);        // clamps to 64
    test_random_groups(40);
    set_rank_count($urandom_range(2, 63));
    test_table_load(1'b0);
    test_random_groups(40);
    set_rank_count($urandom_range(1, MAX_RANKS));
    test_random_groups(40);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && face_records_due.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/sfgm_pkg.sv
hw/rtl/sfgm_group.sv
hw/rtl/sfgm_rank_table.sv
hw/rtl/sorted_face_group_matcher.sv
test/tb.sv
